/* sv/channel_activity_expiry_tracker_top_macros.svh */
// assertion macros shared by the tracker rtl
`ifndef CHANNEL_ACTIVITY_EXPIRY_TRACKER_TOP_MACROS_SVH
`define CHANNEL_ACTIVITY_EXPIRY_TRACKER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CAET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/caet_pkg.sv */
package caet_pkg;

    // fixed field widths
    localparam int CHAN_W      = 4;
    localparam int PORT_TIME_W = 32;
    localparam int HOLD_W      = 32;
    localparam int MASK_W      = 16;
    localparam int NOTE_W      = 8;
    localparam int REQ_W       = 3;
    localparam int STATE_W     = 2;

    localparam logic [NOTE_W-1:0] NOTE_MAX  = 8'd255;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd1000;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TRIGGER   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR_CH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd4;

    // channel state codes
    localparam logic [STATE_W-1:0] CS_OFF   = 2'd0;
    localparam logic [STATE_W-1:0] CS_ON    = 2'd1;
    localparam logic [STATE_W-1:0] CS_EVENT = 2'd2;

endpackage

/* sv/caet_ram.sv */
module caet_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/channel_activity_expiry_tracker_top.sv */
// Channel activity tracker: keeps a trigger count and a held-note count per
// channel and a ring of pending expiries in a single-port-read RAM. One
// request is taken at a time; req_stall stays high until its response has
// been moved into the output register. Trigger, query, clear-all and unused
// codes pass through the execute, head-read and head-latch steps. A time
// update alternates a read step and a compare step on the queue head,
// retiring expired heads until the queue is empty or the head is live. A
// channel clear walks every queued entry through the RAM's read port and
// writes back the ones it keeps. A response stalled at the output holds
// the sequencer in its last step until it is taken.
module channel_activity_expiry_tracker_top
    import caet_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [CHAN_W-1:0]      channel,
    input  logic                   note_event,
    input  logic                   note_on,
    input  logic [PORT_TIME_W-1:0] now,
    // response channel
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [STATE_W-1:0]     chan_state,
    output logic [MASK_W-1:0]      active_mask,
    output logic                   dirty,
    output logic                   expiry_valid,
    output logic [PORT_TIME_W-1:0] next_expiry,
    output logic                   dropped,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [HOLD_W-1:0]      pwdata,
    output logic [HOLD_W-1:0]      prdata,
    output logic                   pready
);

`include "channel_activity_expiry_tracker_top_macros.svh"

    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W  = FILL_W;
    localparam int CI_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W  = CHAN_W + TIME_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UPD_RD,
        ST_UPD_CHK,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_HEAD_RD,
        ST_HEAD_LATCH
    } state_t;

    // queue slot at offset off from base, wrapping at the depth
    function automatic logic [QA_W-1:0] slot(input logic [QA_W-1:0] base,
                                             input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W+1)'(base) + (FILL_W+1)'(off);
        if (sum >= (FILL_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (FILL_W+1)'(QUEUE_DEPTH);
        end
        return QA_W'(sum);
    endfunction

    // configuration register
    logic [HOLD_W-1:0] hold_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg <= HOLD_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            hold_time_reg <= pwdata;
        end
    end

    assign prdata = hold_time_reg;
    assign pready = 1'b1;

    // sequencer state
    state_t                 state_reg, state_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [CHAN_W-1:0]      chan_reg, chan_next;
    logic                   note_ev_reg, note_ev_next;
    logic                   note_on_reg, note_on_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [CNT_W-1:0]       tcount_reg [CHANNELS];
    logic [CNT_W-1:0]       tcount_next [CHANNELS];
    logic [NOTE_W-1:0]      ncount_reg [CHANNELS];
    logic [NOTE_W-1:0]      ncount_next [CHANNELS];
    logic [QA_W-1:0]        head_reg, head_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      k_reg, k_next;
    logic [FILL_W-1:0]      kept_reg, kept_next;
    logic                   dirty_reg, dirty_next;
    logic [STATE_W-1:0]     qstate_reg, qstate_next;
    logic                   lost_reg, lost_next;

    // registered response
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATE_W-1:0]     chan_state_reg, chan_state_next;
    logic [MASK_W-1:0]      active_mask_reg, active_mask_next;
    logic                   dirty_out_reg, dirty_out_next;
    logic                   expiry_valid_reg, expiry_valid_next;
    logic [PORT_TIME_W-1:0] next_expiry_reg, next_expiry_next;
    logic                   dropped_reg, dropped_next;

    // queue ram
    logic                   ram_we;
    logic [QA_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [QA_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;
    logic [CHAN_W-1:0]      rd_chan;
    logic [TIME_BITS-1:0]   rd_expire;

    caet_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_chan   = ram_rdata[ENT_W-1 -: CHAN_W];
    assign rd_expire = ram_rdata[TIME_BITS-1:0];

    // shared count index: queue entry channel while retiring, else request channel
    logic [CHAN_W-1:0]    sel_chan;
    logic                 sel_in_range;
    logic [CI_W-1:0]      sel_idx;
    logic [CNT_W-1:0]     sel_tcount;
    logic [NOTE_W-1:0]    sel_ncount;
    logic [TIME_BITS-1:0] exp_time;

    assign sel_chan     = (state_reg == ST_UPD_CHK) ? rd_chan : chan_reg;
    assign sel_in_range = (32'(sel_chan) < CHANNELS);
    assign sel_idx      = CI_W'(sel_chan);
    assign sel_tcount   = tcount_reg[sel_idx];
    assign sel_ncount   = ncount_reg[sel_idx];
    assign exp_time     = now_reg + TIME_BITS'(hold_time_reg);

    // activity mask over the visible channels
    logic [MASK_W-1:0] mask_now;

    for (genvar c = 0; c < MASK_W; c++)
    begin : g_mask
        if (c < CHANNELS)
        begin : g_live
            assign mask_now[c] = (tcount_reg[c] != '0);
        end
        else
        begin : g_none
            assign mask_now[c] = 1'b0;
        end
    end

    // next-state logic
    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        chan_next         = chan_reg;
        note_ev_next      = note_ev_reg;
        note_on_next      = note_on_reg;
        now_next          = now_reg;
        tcount_next       = tcount_reg;
        ncount_next       = ncount_reg;
        head_next         = head_reg;
        fill_next         = fill_reg;
        k_next            = k_reg;
        kept_next         = kept_reg;
        dirty_next        = dirty_reg;
        qstate_next       = qstate_reg;
        lost_next         = lost_reg;
        rsp_valid_next    = rsp_valid_reg;
        chan_state_next   = chan_state_reg;
        active_mask_next  = active_mask_reg;
        dirty_out_next    = dirty_out_reg;
        expiry_valid_next = expiry_valid_reg;
        next_expiry_next  = next_expiry_reg;
        dropped_next      = dropped_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot(head_reg, fill_reg);
        ram_wdata         = {chan_reg, exp_time};
        ram_re            = 1'b0;
        ram_raddr         = head_reg;

        // response taken downstream
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req_type;
                    chan_next    = channel;
                    note_ev_next = note_event;
                    note_on_next = note_on;
                    now_next     = TIME_BITS'(now);
                    qstate_next  = CS_OFF;
                    lost_next    = 1'b0;
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_HEAD_RD;
                case (req_reg)
                    REQ_TRIGGER:
                    begin
                        if (sel_in_range)
                        begin
                            if (fill_reg == FILL_W'(QUEUE_DEPTH))
                            begin
                                lost_next = 1'b1;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                fill_next            = fill_reg + 1'b1;
                                tcount_next[sel_idx] = sel_tcount + 1'b1;
                                if (sel_tcount == '0)
                                begin
                                    dirty_next = 1'b1;
                                end
                                if (note_ev_reg && note_on_reg && sel_ncount < NOTE_MAX)
                                begin
                                    ncount_next[sel_idx] = sel_ncount + 1'b1;
                                    if (sel_ncount == '0)
                                    begin
                                        dirty_next = 1'b1;
                                    end
                                end
                                else if (note_ev_reg && !note_on_reg && sel_ncount != '0)
                                begin
                                    ncount_next[sel_idx] = sel_ncount - 1'b1;
                                    if (sel_ncount == NOTE_W'(1))
                                    begin
                                        dirty_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end

                    REQ_UPDATE:
                    begin
                        state_next = ST_UPD_RD;
                    end

                    REQ_QUERY:
                    begin
                        dirty_next = 1'b0;
                        if (sel_in_range)
                        begin
                            if (sel_tcount != '0)
                            begin
                                qstate_next = CS_EVENT;
                            end
                            else if (sel_ncount != '0)
                            begin
                                qstate_next = CS_ON;
                            end
                        end
                    end

                    REQ_CLEAR_CH:
                    begin
                        if (sel_in_range)
                        begin
                            tcount_next[sel_idx] = '0;
                            ncount_next[sel_idx] = '0;
                            dirty_next           = 1'b1;
                            k_next               = '0;
                            kept_next            = '0;
                            state_next           = ST_CLR_RD;
                        end
                    end

                    REQ_CLEAR_ALL:
                    begin
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            tcount_next[c] = '0;
                            ncount_next[c] = '0;
                        end
                        head_next  = '0;
                        fill_next  = '0;
                        dirty_next = 1'b1;
                    end

                    default:
                    begin
                    end
                endcase
            end

            // retire expired heads, one per read and compare
            ST_UPD_RD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_UPD_CHK;
                end
            end

            ST_UPD_CHK:
            begin
                if (now_reg >= rd_expire)
                begin
                    if (sel_in_range && sel_tcount != '0)
                    begin
                        tcount_next[sel_idx] = sel_tcount - 1'b1;
                        if (sel_tcount == CNT_W'(1))
                        begin
                            dirty_next = 1'b1;
                        end
                    end
                    head_next  = slot(head_reg, FILL_W'(1));
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_UPD_RD;
                end
                else
                begin
                    // read data already holds the live head
                    state_next = ST_HEAD_LATCH;
                end
            end

            // compact the queue, dropping the cleared channel
            ST_CLR_RD:
            begin
                if (k_reg == fill_reg)
                begin
                    fill_next  = kept_reg;
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, k_reg);
                    state_next = ST_CLR_WR;
                end
            end

            ST_CLR_WR:
            begin
                if (rd_chan != chan_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(head_reg, kept_reg);
                    ram_wdata = ram_rdata;
                    kept_next = kept_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = ST_CLR_RD;
            end

            ST_HEAD_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_HEAD_LATCH;
            end

            // load the response once the output register is free
            ST_HEAD_LATCH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next    = 1'b1;
                    chan_state_next   = qstate_reg;
                    active_mask_next  = mask_now;
                    dirty_out_next    = dirty_reg;
                    expiry_valid_next = (fill_reg != '0);
                    next_expiry_next  = (fill_reg != '0) ? PORT_TIME_W'(rd_expire) : '0;
                    dropped_next      = lost_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            req_reg          <= REQ_TRIGGER;
            chan_reg         <= '0;
            note_ev_reg      <= 1'b0;
            note_on_reg      <= 1'b0;
            now_reg          <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                tcount_reg[c] <= '0;
                ncount_reg[c] <= '0;
            end
            head_reg         <= '0;
            fill_reg         <= '0;
            k_reg            <= '0;
            kept_reg         <= '0;
            dirty_reg        <= 1'b1;
            qstate_reg       <= CS_OFF;
            lost_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            chan_state_reg   <= CS_OFF;
            active_mask_reg  <= '0;
            dirty_out_reg    <= 1'b0;
            expiry_valid_reg <= 1'b0;
            next_expiry_reg  <= '0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            req_reg          <= req_next;
            chan_reg         <= chan_next;
            note_ev_reg      <= note_ev_next;
            note_on_reg      <= note_on_next;
            now_reg          <= now_next;
            tcount_reg       <= tcount_next;
            ncount_reg       <= ncount_next;
            head_reg         <= head_next;
            fill_reg         <= fill_next;
            k_reg            <= k_next;
            kept_reg         <= kept_next;
            dirty_reg        <= dirty_next;
            qstate_reg       <= qstate_next;
            lost_reg         <= lost_next;
            rsp_valid_reg    <= rsp_valid_next;
            chan_state_reg   <= chan_state_next;
            active_mask_reg  <= active_mask_next;
            dirty_out_reg    <= dirty_out_next;
            expiry_valid_reg <= expiry_valid_next;
            next_expiry_reg  <= next_expiry_next;
            dropped_reg      <= dropped_next;
        end
    end

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign chan_state   = chan_state_reg;
    assign active_mask  = active_mask_reg;
    assign dirty        = dirty_out_reg;
    assign expiry_valid = expiry_valid_reg;
    assign next_expiry  = next_expiry_reg;
    assign dropped      = dropped_reg;

    // checks
    `CAET_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(QUEUE_DEPTH), "queue fill over depth")
    `CAET_ASSERT_NOW(a_rsp_from_latch, $rose(rsp_valid_reg), $past(state_reg) == ST_HEAD_LATCH, "response raised outside latch step")
    `CAET_ASSERT_NEXT(a_clear_all_empty, state_reg == ST_EXEC && req_reg == REQ_CLEAR_ALL, fill_reg == '0 && head_reg == '0, "clear all left queue entries")
    `CAET_ASSERT_NEXT(a_full_drops, state_reg == ST_EXEC && req_reg == REQ_TRIGGER && sel_in_range && fill_reg == FILL_W'(QUEUE_DEPTH), lost_reg && fill_reg == FILL_W'(QUEUE_DEPTH), "full queue trigger not dropped")
    `CAET_ASSERT_NOW(a_compact_order, state_reg == ST_CLR_RD || state_reg == ST_CLR_WR, kept_reg <= k_reg && k_reg <= fill_reg, "compaction pointers out of order")

endmodule
